[sv/prcf_pkg.sv]
// ----------------------------------------------------------------------------
// prcf_pkg
// Shared types, constants and helper functions for the planar roll
// complementary filter.
// ----------------------------------------------------------------------------
package prcf_pkg;

  localparam int ANGLE_TABLE_LEN = 24;
  localparam int IDX_W           = 5;
  localparam int XY_W            = 27;
  localparam int Z_W             = 26;
  localparam int ANGLE_W         = 25;
  localparam int ATAN_W          = 22;

  localparam logic signed [Z_W-1:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [Z_W-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic [16:0]           ONE_Q16    = 17'd65536;

  localparam logic [23:0] SAMPLE_PERIOD_RESET = 24'd16777;
  localparam logic [16:0] BLEND_WEIGHT_RESET  = 17'd62259;

  localparam logic REG_SAMPLE_PERIOD = 1'b0;
  localparam logic REG_BLEND_WEIGHT  = 1'b1;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] idx;
  } cordic_ctl_t;

  function automatic logic [ATAN_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117305;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/prcf_cordic.sv]
// ----------------------------------------------------------------------------
// prcf_cordic
// Vectoring CORDIC datapath for atan2(x, y) in Q16.16 degrees, one
// micro-rotation per step under control of the top-level sequencer.
// ----------------------------------------------------------------------------
module prcf_cordic (
  input  logic                                  clk,
  input  prcf_pkg::cordic_ctl_t                 ctl,
  input  logic signed [15:0]                    accel_x,
  input  logic signed [15:0]                    accel_y,
  output logic signed [prcf_pkg::ANGLE_W-1:0]   angle
);
  import prcf_pkg::*;

  logic signed [XY_W-1:0] px_r, px_nxt;
  logic signed [XY_W-1:0] py_r, py_nxt;
  logic signed [Z_W-1:0]  z_r, z_nxt;
  logic                   zero_r, zero_nxt;

  logic signed [XY_W-1:0] px0;
  logic signed [XY_W-1:0] py0;
  logic signed [XY_W-1:0] sh_x;
  logic signed [XY_W-1:0] sh_y;
  logic signed [Z_W-1:0]  atan_z;

  assign px0    = XY_W'({{(XY_W-24){accel_y[15]}}, accel_y, 8'd0});
  assign py0    = XY_W'({{(XY_W-24){accel_x[15]}}, accel_x, 8'd0});
  assign sh_x   = py_r >>> ctl.idx;
  assign sh_y   = px_r >>> ctl.idx;
  assign atan_z = Z_W'({{(Z_W-ATAN_W){1'b0}}, atan_entry(ctl.idx)});

  always_comb begin
    px_nxt   = px_r;
    py_nxt   = py_r;
    z_nxt    = z_r;
    zero_nxt = zero_r;
    if (ctl.load) begin
      zero_nxt = (accel_x == 16'sd0) && (accel_y == 16'sd0);
      if (accel_y < 16'sd0) begin
        if (accel_x >= 16'sd0) begin
          px_nxt = py0;
          py_nxt = -px0;
          z_nxt  = DEG90_Q16;
        end else begin
          px_nxt = -py0;
          py_nxt = px0;
          z_nxt  = -DEG90_Q16;
        end
      end else begin
        px_nxt = px0;
        py_nxt = py0;
        z_nxt  = '0;
      end
    end else if (ctl.step) begin
      if (py_r > 0) begin
        px_nxt = px_r + sh_x;
        py_nxt = py_r - sh_y;
        z_nxt  = z_r + atan_z;
      end else begin
        px_nxt = px_r - sh_x;
        py_nxt = py_r + sh_y;
        z_nxt  = z_r - atan_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
  end

  always_comb begin
    if (zero_r) begin
      angle = '0;
    end else if (z_r > DEG180_Q16) begin
      angle = DEG180_Q16[ANGLE_W-1:0];
    end else if (z_r < -DEG180_Q16) begin
      angle = ANGLE_W'(-DEG180_Q16);
    end else begin
      angle = z_r[ANGLE_W-1:0];
    end
  end

endmodule

[sv/planar_roll_complementary_filter.sv]
// ----------------------------------------------------------------------------
// planar_roll_complementary_filter
// Planar roll estimator: integrates the gyro rate and blends it with the
// accelerometer roll from a CORDIC atan2, one IMU sample per transfer.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    accel_x, accel_y, gyro_rate_z
//   out_     output     out_valid / out_ready  gyro_roll, accel_roll,
//                                              blended_roll
//   cfg      input      psel/penable/pwrite    sample_period (0x0),
//                                              blend_weight (0x4)
//
// The time from input transfer to result is set by the CORDIC
// micro-rotations (at most 24) and three passes through the shared
// multiplier. in_ready is high only while the sequencer is idle.
// A finished result waits in the output register while the next sample is
// accepted; the sequencer stalls only when a second result is ready first.
// Synchronous reset clears both roll estimates and restores the registers.
// ----------------------------------------------------------------------------
module planar_roll_complementary_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  in_accel_x,
  input  logic signed [15:0]                  in_accel_y,
  input  logic signed [27:0]                  in_gyro_rate_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_gyro_roll,
  output logic signed [prcf_pkg::ANGLE_W-1:0] out_accel_roll,
  output logic signed [31:0]                  out_blended_roll,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import prcf_pkg::*;

  localparam int STEPS_EFF = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN :
                             CORDIC_STEPS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEPS_EFF - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL_DT = 10'b0000000010,
    S_ROUND  = 10'b0000000100,
    S_SUM    = 10'b0000001000,
    S_CORDIC = 10'b0000010000,
    S_CLAMP  = 10'b0000100000,
    S_MUL_A  = 10'b0001000000,
    S_MUL_B  = 10'b0010000000,
    S_ADD    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0]              sample_period_r, sample_period_nxt;
  logic [16:0]              blend_weight_r, blend_weight_nxt;
  logic signed [31:0]       gyro_est_r, gyro_est_nxt;
  logic signed [31:0]       blended_est_r, blended_est_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;

  logic signed [27:0]       rate_r;
  logic signed [52:0]       prod_r;
  logic signed [28:0]       delta_r;
  logic signed [32:0]       sum_r;
  logic signed [52:0]       accum_r;
  logic signed [ANGLE_W-1:0] acc_roll_r;
  logic signed [31:0]       out_gyro_roll_r;
  logic signed [ANGLE_W-1:0] out_accel_roll_r;
  logic signed [31:0]       out_blended_roll_r;

  logic                     cfg_write;
  logic                     in_fire;
  logic                     out_load;
  logic [16:0]              alpha;
  logic [16:0]              one_minus_alpha;
  logic signed [32:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [57:0]       mul_full;
  logic signed [52:0]       round_sum;
  logic signed [32:0]       gyro_sum;
  logic signed [52:0]       blend_sum;
  logic signed [ANGLE_W-1:0] cordic_angle;
  cordic_ctl_t              cordic_ctl;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    case (paddr[2])
      REG_SAMPLE_PERIOD: prdata = {8'd0, sample_period_r};
      REG_BLEND_WEIGHT:  prdata = {15'd0, blend_weight_r};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    sample_period_nxt = sample_period_r;
    blend_weight_nxt  = blend_weight_r;
    if (cfg_write) begin
      case (paddr[2])
        REG_SAMPLE_PERIOD: sample_period_nxt = pwdata[23:0];
        REG_BLEND_WEIGHT:  blend_weight_nxt  = pwdata[16:0];
        default:           sample_period_nxt = sample_period_r;
      endcase
    end
  end

  assign alpha           = (blend_weight_r > ONE_Q16) ? ONE_Q16 : blend_weight_r;
  assign one_minus_alpha = ONE_Q16 - alpha;

  always_comb begin
    case (state_r)
      S_MUL_DT: begin
        mul_a = 33'(rate_r);
        mul_b = $signed({1'b0, sample_period_r});
      end
      S_MUL_A: begin
        mul_a = sum_r;
        mul_b = $signed({8'd0, alpha});
      end
      S_MUL_B: begin
        mul_a = 33'(acc_roll_r);
        mul_b = $signed({8'd0, one_minus_alpha});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full  = mul_a * mul_b;
  assign round_sum = prod_r + 53'sd8388608;
  assign gyro_sum  = 33'(gyro_est_r) + 33'(delta_r);
  assign blend_sum = accum_r + prod_r;

  assign cordic_ctl.load = in_fire;
  assign cordic_ctl.step = (state_r == S_CORDIC);
  assign cordic_ctl.idx  = idx_r;

  prcf_cordic u_cordic (
    .clk     (clk),
    .ctl     (cordic_ctl),
    .accel_x (in_accel_x),
    .accel_y (in_accel_y),
    .angle   (cordic_angle)
  );

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    gyro_est_nxt    = gyro_est_r;
    blended_est_nxt = blended_est_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL_DT;
        end
      end
      S_MUL_DT: state_nxt = S_ROUND;
      S_ROUND:  state_nxt = S_SUM;
      S_SUM: begin
        gyro_est_nxt = sat32(37'(gyro_sum));
        idx_nxt      = '0;
        state_nxt    = S_CORDIC;
      end
      S_CORDIC: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP:  state_nxt = S_MUL_A;
      S_MUL_A:  state_nxt = S_MUL_B;
      S_MUL_B:  state_nxt = S_ADD;
      S_ADD: begin
        blended_est_nxt = sat32(blend_sum[52:16]);
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      sample_period_r <= SAMPLE_PERIOD_RESET;
      blend_weight_r  <= BLEND_WEIGHT_RESET;
      gyro_est_r      <= '0;
      blended_est_r   <= '0;
      out_valid_r     <= 1'b0;
      idx_r           <= '0;
    end else begin
      state_r         <= state_nxt;
      sample_period_r <= sample_period_nxt;
      blend_weight_r  <= blend_weight_nxt;
      gyro_est_r      <= gyro_est_nxt;
      blended_est_r   <= blended_est_nxt;
      out_valid_r     <= out_valid_nxt;
      idx_r           <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rate_r <= in_gyro_rate_z;
    end
    if ((state_r == S_MUL_DT) || (state_r == S_MUL_A) || (state_r == S_MUL_B)) begin
      prod_r <= mul_full[52:0];
    end
    if (state_r == S_ROUND) begin
      delta_r <= round_sum[52:24];
    end
    if (state_r == S_SUM) begin
      sum_r <= 33'(blended_est_r) + 33'(delta_r);
    end
    if (state_r == S_CLAMP) begin
      acc_roll_r <= cordic_angle;
    end
    if (state_r == S_MUL_B) begin
      accum_r <= prod_r + 53'sd32768;
    end
    if (out_load) begin
      out_gyro_roll_r    <= gyro_est_r;
      out_accel_roll_r   <= acc_roll_r;
      out_blended_roll_r <= blended_est_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gyro_roll    = out_gyro_roll_r;
  assign out_accel_roll   = out_accel_roll_r;
  assign out_blended_roll = out_blended_roll_r;

endmodule

[tb/sv/planar_roll_complementary_filter_tb.sv]
// ----------------------------------------------------------------------------
// planar_roll_complementary_filter_tb
// Self-checking testbench for the planar roll complementary filter. A small
// scoreboard class keeps its own gyro and blended roll estimates and its own
// vectoring CORDIC, predicts each result as a sample transfer is accepted,
// and compares every result transfer field by field. Directed samples cover
// the axes, the zero vector and the left half plane. Random samples then run
// under many register settings, with random idling on both channels, a long
// receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module planar_roll_complementary_filter_tb;
  import prcf_pkg::*;

  localparam int CORDIC_STEPS  = 16;
  localparam int SETTLE_CYCLES = CORDIC_STEPS + 20;
  localparam int PHASE_ITEMS   = 190;
  localparam int PHASE_COUNT   = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [2:0] ADDR_SAMPLE_PERIOD = {REG_SAMPLE_PERIOD, 2'b00};
  localparam logic [2:0] ADDR_BLEND_WEIGHT  = {REG_BLEND_WEIGHT, 2'b00};

  localparam logic signed [27:0] RATE_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] RATE_MIN = 28'sh8000000;

  localparam longint ATAN_DEG_Q16 [ANGLE_TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef enum int {
    RATE_ANY,
    RATE_HIGH,
    RATE_LOW,
    RATE_SMALL
  } rate_mode_t;

  typedef struct {
    logic signed [31:0]        gyro_roll;
    logic signed [ANGLE_W-1:0] accel_roll;
    logic signed [31:0]        blended_roll;
  } roll_triple_t;

  class roll_scoreboard;
    longint       period_q24;
    longint       weight_q16;
    longint       gyro_estimate;
    longint       blended_estimate;
    roll_triple_t expected_rolls[$];
    int           mismatch_count;

    function new();
      period_q24       = SAMPLE_PERIOD_RESET;
      weight_q16       = BLEND_WEIGHT_RESET;
      gyro_estimate    = 0;
      blended_estimate = 0;
      mismatch_count   = 0;
    endfunction

    function int outstanding();
      return expected_rolls.size();
    endfunction

    function void write_register(logic [2:0] addr, logic [31:0] data);
      if (addr == ADDR_SAMPLE_PERIOD) begin
        period_q24 = data[23:0];
      end else if (addr == ADDR_BLEND_WEIGHT) begin
        weight_q16 = data[16:0];
      end
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint atan2_deg(longint x, longint y);
      longint px;
      longint py;
      longint z;
      longint t;
      longint dx;
      longint dy;
      int     steps;
      px = y * 256;
      py = x * 256;
      z = 0;
      if (x == 0 && y == 0) begin
        return 0;
      end
      steps = (CORDIC_STEPS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN : CORDIC_STEPS;
      if (px < 0) begin
        if (py >= 0) begin
          t = px;
          px = py;
          py = -t;
          z = 5898240;
        end else begin
          t = px;
          px = -py;
          py = t;
          z = -5898240;
        end
      end
      for (int i = 0; i < steps; i++) begin
        dx = py >>> i;
        dy = px >>> i;
        if (py > 0) begin
          px += dx;
          py -= dy;
          z += ATAN_DEG_Q16[i];
        end else begin
          px -= dx;
          py += dy;
          z -= ATAN_DEG_Q16[i];
        end
      end
      if (z > 11796480) begin
        z = 11796480;
      end
      if (z < -11796480) begin
        z = -11796480;
      end
      return z;
    endfunction

    function void advance_estimates(logic signed [15:0] ax, logic signed [15:0] ay,
                                    logic signed [27:0] rate);
      longint       alpha;
      longint       delta;
      longint       tilt;
      longint       sum;
      longint       mix;
      longint       rate_l;
      roll_triple_t r;
      rate_l = rate;
      alpha = (weight_q16 > 65536) ? 65536 : weight_q16;
      delta = (rate_l * period_q24 + (64'sd1 <<< 23)) >>> 24;
      gyro_estimate = clamp32(gyro_estimate + delta);
      tilt = atan2_deg(longint'(ax), longint'(ay));
      sum = blended_estimate + delta;
      mix = alpha * sum + (65536 - alpha) * tilt;
      blended_estimate = clamp32((mix + 64'sd32768) >>> 16);
      r.gyro_roll    = gyro_estimate[31:0];
      r.accel_roll   = tilt[ANGLE_W-1:0];
      r.blended_roll = blended_estimate[31:0];
      expected_rolls.push_back(r);
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_result(logic signed [31:0] gyro, logic signed [ANGLE_W-1:0] tilt,
                      logic signed [31:0] blended);
      roll_triple_t r;
      if (expected_rolls.size() == 0) begin
        report($sformatf("unexpected result %0d %0d %0d", gyro, tilt, blended));
      end else begin
        r = expected_rolls.pop_front();
        if (gyro !== r.gyro_roll) begin
          report($sformatf("gyro_roll got %0d expected %0d", gyro, r.gyro_roll));
        end
        if (tilt !== r.accel_roll) begin
          report($sformatf("accel_roll got %0d expected %0d", tilt, r.accel_roll));
        end
        if (blended !== r.blended_roll) begin
          report($sformatf("blended_roll got %0d expected %0d", blended,
                           r.blended_roll));
        end
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [15:0]        in_accel_x;
  logic signed [15:0]        in_accel_y;
  logic signed [27:0]        in_gyro_rate_z;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [31:0]        out_gyro_roll;
  logic signed [ANGLE_W-1:0] out_accel_roll;
  logic signed [31:0]        out_blended_roll;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  roll_scoreboard tracker = new();
  int             send_gap_max = 15;
  int             recv_stall_max = 15;
  int             hold_request = 0;

  planar_roll_complementary_filter #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_accel_x(in_accel_x),
    .in_accel_y(in_accel_y),
    .in_gyro_rate_z(in_gyro_rate_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_gyro_roll(out_gyro_roll),
    .out_accel_roll(out_accel_roll),
    .out_blended_roll(out_blended_roll),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [27:0] rate);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_accel_x     = ax;
    in_accel_y     = ay;
    in_gyro_rate_z = rate;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.advance_estimates(ax, ay, rate);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracker.write_register(addr, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic retune(input logic [23:0] period, input logic [16:0] weight);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    apb_write(ADDR_SAMPLE_PERIOD, 32'(period));
    apb_write(ADDR_BLEND_WEIGHT, 32'(weight));
  endtask

  task automatic send_random_sample(input rate_mode_t mode);
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [27:0] rate;
    int                 pick;
    pick = $urandom_range(0, 9);
    ax = 16'($urandom);
    ay = 16'($urandom);
    if (pick == 0) begin
      ax = 16'($signed($urandom_range(0, 6)) - 3);
      ay = 16'($signed($urandom_range(0, 6)) - 3);
    end else if (pick == 1) begin
      ay = -16'sd1 - 16'($urandom_range(0, 32767));
    end else if (pick == 2) begin
      ax = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
      ay = ($urandom_range(0, 2) == 0) ? 16'sd0 : ay;
    end
    case (mode)
      RATE_HIGH:  rate = 28'($urandom_range(1 << 26, (1 << 27) - 1));
      RATE_LOW:   rate = -28'($urandom_range(1 << 26, 1 << 27));
      RATE_SMALL: rate = 28'($signed($urandom_range(0, 2047)) - 1024);
      default:    rate = 28'($urandom);
    endcase
    send_sample(ax, ay, rate);
  endtask

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      stall = $urandom_range(0, recv_stall_max);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_result(out_gyro_roll, out_accel_roll, out_blended_roll);
    end
  end

  initial begin
    logic [23:0] period;
    logic [16:0] weight;
    rate_mode_t  mode;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_accel_x     = '0;
    in_accel_y     = '0;
    in_gyro_rate_z = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_sample(16'sd0, 16'sd0, 28'sd0);
    send_sample(16'sd0, 16'sh8000, RATE_MAX);
    send_sample(-16'sd1, 16'sh8000, 28'sd0);
    send_sample(16'sh7FFF, 16'sd0, 28'sd1);
    send_sample(16'sh8000, 16'sd0, -28'sd1);
    send_sample(16'sd0, 16'sh7FFF, RATE_MIN);
    send_sample(16'sh7FFF, 16'sh7FFF, RATE_MAX);
    send_sample(16'sh8000, 16'sh8000, RATE_MIN);
    send_sample(16'sh7FFF, 16'sh8000, 28'sd65536);
    send_sample(16'sh8000, 16'sh7FFF, -28'sd65536);
    send_sample(16'sd1, -16'sd1, 28'sd0);
    send_sample(-16'sd1, -16'sd1, 28'sd0);
    send_sample(16'sd1, 16'sd1, 28'sd0);
    send_sample(-16'sd1, 16'sd1, 28'sd0);
    send_sample(16'sd0, 16'sd1, 28'sd0);
    send_sample(16'sd1, 16'sd0, 28'sd0);
    send_sample(-16'sd1, 16'sd0, 28'sd0);
    send_sample(16'sd0, -16'sd1, 28'sd0);
    send_sample(16'sd0, 16'sd0, RATE_MAX);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      period = 24'($urandom);
      weight = 17'($urandom_range(0, ONE_Q16));
      case (ph)
        0: begin
          period = 24'hFFFFFF;
          weight = ONE_Q16;
        end
        1: begin
          period = 24'd0;
          weight = 17'd0;
        end
        2: weight = 17'h1FFFF;
        3: begin
          period = 24'd1;
          weight = 17'd1;
        end
        4: begin
          period = 24'hFFFFFF;
          weight = 17'd0;
        end
        5: begin
          period = 24'd0;
          weight = ONE_Q16;
        end
        6: weight = 17'($urandom_range(ONE_Q16 + 1, 17'h1FFFF));
        default: ;
      endcase
      retune(period, weight);
      mode = RATE_ANY;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 32 == 0) begin
          mode = rate_mode_t'($urandom_range(0, 3));
        end
        send_gap_max   = ((k % 64) >= 48) ? 0 : 15;
        recv_stall_max = send_gap_max;
        if (ph == 2 && k == 30) begin
          hold_request = HOLD_CYCLES;
        end
        if (ph == 4 && k == 60) begin
          drain_results();
        end
        send_random_sample(mode);
      end
    end

    send_gap_max   = 15;
    recv_stall_max = 15;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/prcf_pkg.sv
sv/prcf_cordic.sv
sv/planar_roll_complementary_filter.sv
tb/sv/planar_roll_complementary_filter_tb.sv
